### rtl/core/scancode_set1_key_decoder_unit_assert.svh
// Assertion macros used by the checker module of the key decoder.
`ifndef SCANCODE_SET1_KEY_DECODER_UNIT_ASSERT_SVH
`define SCANCODE_SET1_KEY_DECODER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SCD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define SCD_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/scd_pkg.sv
package scd_pkg;

    localparam int KEY_COUNT     = 256;
    localparam int TABLE_ENTRIES = 58;
    localparam int TABLE_SIZE    = 58;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [7:0] LOW_MASK    = 8'h7F;
    localparam logic [7:0] HIGH_BIT    = 8'h80;
    localparam logic [7:0] LSHIFT_KEY  = 8'h2A;
    localparam logic [7:0] RSHIFT_KEY  = 8'h36;

    localparam logic ACTION_SCAN  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;
    localparam logic KIND_EVENT   = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    typedef logic [6:0] t_char;

    typedef struct packed {
        logic        action;
        logic [7:0]  scan_byte;
        logic [7:0]  query_key;
        logic [31:0] time_stamp;
    } t_key_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  event_key;
        t_char       character;
        logic [31:0] event_time;
        logic        pressed;
    } t_key_out;

    localparam t_char PLAIN_MAP [TABLE_SIZE] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
        7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
        7'h70, 7'h5B, 7'h5D, 7'h0A,
        7'h01, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
        7'h3B, 7'h27, 7'h60, 7'h02,
        7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E,
        7'h2F, 7'h03, 7'h2A, 7'h04, 7'h20
    };

    localparam t_char UPPER_MAP [TABLE_SIZE] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08,
        7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
        7'h50, 7'h7B, 7'h7D, 7'h0A,
        7'h01, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C,
        7'h3A, 7'h22, 7'h7E, 7'h02,
        7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E,
        7'h3F, 7'h03, 7'h2A, 7'h04, 7'h20
    };

    // Keys past the end of the US layout translate to no character.
    function automatic t_char lookup_char(input logic [7:0] idx, input logic upper);
        t_char ch;
        ch = '0;
        if ((int'(idx) < TABLE_ENTRIES) && (int'(idx) < TABLE_SIZE)) begin
            ch = upper ? UPPER_MAP[idx[5:0]] : PLAIN_MAP[idx[5:0]];
        end
        return ch;
    endfunction

endpackage

### rtl/core/scancode_set1_key_decoder_unit.sv
// Scan code set 1 key decoder. Each transaction on the input channel carries either a
// keyboard byte or a query for one key's pressed state; unless stalled, the block accepts
// one transaction per clock and returns at most one result, which passes through the
// input register, where the byte is decoded against the shift, prefix and pressed-key
// flags, and then the result register. The input stalls only while the result register
// is full and held by a stalled output and the waiting transaction produces a result.
module scancode_set1_key_decoder_unit
    import scd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_key_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_key_out o_out_data
);

    logic                 r_in_valid;
    t_key_in              r_in;
    logic                 r_out_valid;
    t_key_out             r_out;
    logic [KEY_COUNT-1:0] r_pressed;
    logic                 r_shift;
    logic                 r_ext;

    logic       is_query;
    logic       is_prefix;
    logic       is_release;
    logic       is_shift;
    logic [7:0] key_idx;
    t_char      key_char;
    logic       has_result;
    logic       out_free;
    logic       advance;
    t_key_out   n_out;

    always_comb begin
        is_query   = (r_in.action == ACTION_QUERY);
        is_prefix  = (r_in.scan_byte == PREFIX_BYTE);
        is_release = ((r_in.scan_byte & HIGH_BIT) != 8'h00);
        key_idx    = (r_in.scan_byte & LOW_MASK) | (r_ext ? HIGH_BIT : 8'h00);
        is_shift   = (key_idx == LSHIFT_KEY) || (key_idx == RSHIFT_KEY);
        key_char   = lookup_char(key_idx, r_shift);
        has_result = is_query ||
                     (!is_prefix && !is_release && !is_shift && (key_char != '0));
        out_free   = !r_out_valid || !i_out_stall;
        advance    = r_in_valid && (!has_result || out_free);

        if (is_query) begin
            n_out.kind       = KIND_REPLY;
            n_out.event_key  = r_in.query_key;
            n_out.character  = '0;
            n_out.pressed    = r_pressed[r_in.query_key];
        end else begin
            n_out.kind       = KIND_EVENT;
            n_out.event_key  = key_idx;
            n_out.character  = key_char;
            n_out.pressed    = 1'b1;
        end
        n_out.event_time = r_in.time_stamp;
    end

    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && has_result) begin
            r_out <= n_out;
        end
    end

    // Key state changes only when the scan byte leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= '0;
            r_shift   <= 1'b0;
            r_ext     <= 1'b0;
        end else if (advance && !is_query) begin
            if (is_prefix) begin
                r_ext <= 1'b1;
            end else begin
                r_pressed[key_idx] <= !is_release;
                if (is_shift) begin
                    r_shift <= !is_release;
                end
                r_ext <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/scd_checker.sv
`include "scancode_set1_key_decoder_unit_assert.svh"

module scd_checker
    import scd_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_key_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_key_out o_out_data
);

    // The input may only back up behind a result that the output side is holding off.
    `SCD_ASSERT_RST(a_stall_needs_full_out, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled without a held result")

    `SCD_ASSERT_ANY(a_no_result_after_reset, i_clk, !i_rst_n |=> !o_out_valid, "result valid right after reset")

    `SCD_ASSERT_RST(a_out_valid_holds, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid, "result dropped while stalled")

    `SCD_ASSERT_RST(a_out_data_holds, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> $stable(o_out_data), "result changed while stalled")

    // A stalled input transaction is held unchanged by the sender.
    `SCD_ASSERT_RST(a_in_data_holds, i_clk, i_rst_n, (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)), "stalled input changed")

endmodule

bind scancode_set1_key_decoder_unit scd_checker u_scd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
